// ===== design/box_to_textured_quads_core_assert.svh =====
// Assertion macros for the box-to-quad expander checker.
// Both macros expect signals named clk and arst_n in the using scope.
`ifndef BOX_TO_TEXTURED_QUADS_CORE_ASSERT_SVH
`define BOX_TO_TEXTURED_QUADS_CORE_ASSERT_SVH

// Clocked property, disabled while reset is low.
`define BTQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A stalled request keeps valid and its payload.
`define BTQ_ASSERT_HOLD(label, vld, rdy, sig, msg) \
	`BTQ_ASSERT(label, (vld && !rdy) |=> (vld && $stable(sig)), msg)

`endif

// ===== design/btq_pkg.sv =====
// ----------------------------------------------------------------------------
// btq_pkg
// Types, constants and lookup tables for the box-to-quad vertex expander.
// ----------------------------------------------------------------------------
`default_nettype none

package btq_pkg;

	localparam int FACE_VERTS  = 6 * 4;
	localparam int CNT_W       = $clog2(FACE_VERTS);
	localparam int TEX_W       = 11;
	localparam int NUM_U       = 6;
	localparam int NUM_V       = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic MODE_PLAIN = 1'b0;
	localparam logic MODE_ROT   = 1'b1;

	// Texture column taps: origin plus sums of side (S) and body (B) widths
	localparam logic [2:0] U_ORG  = 3'd0;
	localparam logic [2:0] U_S    = 3'd1;
	localparam logic [2:0] U_SB   = 3'd2;
	localparam logic [2:0] U_SSB  = 3'd3;
	localparam logic [2:0] U_SBB  = 3'd4;
	localparam logic [2:0] U_SSBB = 3'd5;
	// Texture row taps: origin, plus side, plus side and body height
	localparam logic [1:0] V_ORG  = 2'd0;
	localparam logic [1:0] V_S    = 2'd1;
	localparam logic [1:0] V_SH   = 2'd2;

	// Bit positions of the corner select (1 picks the hi corner)
	localparam int SEL_X = 2;
	localparam int SEL_Y = 1;
	localparam int SEL_Z = 0;

	typedef logic [TEX_W-1:0] tex_t;

	typedef enum logic [2:0] {
		FACE_TOP,
		FACE_BOTTOM,
		FACE_FRONT,
		FACE_BACK,
		FACE_LEFT,
		FACE_RIGHT
	} face_t;

	typedef struct packed {
		logic              mode;
		logic [9:0]        tex_x;
		logic [9:0]        tex_y;
		logic [7:0]        sides_w;
		logic [7:0]        body_w;
		logic [7:0]        body_h;
		logic signed [15:0] lo_x;
		logic signed [15:0] lo_y;
		logic signed [15:0] lo_z;
		logic signed [15:0] hi_x;
		logic signed [15:0] hi_y;
		logic signed [15:0] hi_z;
	} box_t;

	typedef struct packed {
		logic [15:0]        vertex_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [10:0]        tex_u;
		logic [10:0]        tex_v;
		logic               last;
	} vtx_t;

	// One classified box waiting for the sequencer
	typedef struct packed {
		logic               mode;
		tex_t [NUM_U-1:0]   u;
		tex_t [NUM_V-1:0]   v;
		logic signed [15:0] lo_x;
		logic signed [15:0] lo_y;
		logic signed [15:0] lo_z;
		logic signed [15:0] hi_x;
		logic signed [15:0] hi_y;
		logic signed [15:0] hi_z;
	} job_t;

	typedef struct packed {
		logic [2:0] u_lo;
		logic [2:0] u_hi;
		logic [1:0] v_lo;
		logic [1:0] v_hi;
	} face_tex_t;

	// Corner select per vertex, {x, y, z}; left/right Y-Z swap of the
	// rotated layout is folded into its table.
	localparam logic [2:0] SEL_PLAIN [FACE_VERTS] = '{
		3'b110, 3'b111, 3'b011, 3'b010,
		3'b100, 3'b101, 3'b001, 3'b000,
		3'b100, 3'b110, 3'b010, 3'b000,
		3'b001, 3'b011, 3'b111, 3'b101,
		3'b101, 3'b111, 3'b110, 3'b100,
		3'b000, 3'b010, 3'b011, 3'b001
	};

	localparam logic [2:0] SEL_ROT [FACE_VERTS] = '{
		3'b011, 3'b010, 3'b110, 3'b111,
		3'b101, 3'b100, 3'b000, 3'b001,
		3'b100, 3'b110, 3'b010, 3'b000,
		3'b011, 3'b001, 3'b101, 3'b111,
		3'b111, 3'b110, 3'b100, 3'b101,
		3'b001, 3'b000, 3'b010, 3'b011
	};

	function automatic face_tex_t face_tex(input logic mode, input face_t face);
		face_tex_t ft;
		case (face)
			FACE_TOP:    ft = (mode == MODE_ROT) ? face_tex_t'{U_SSB, U_SSBB, V_S, V_SH}
			                                     : face_tex_t'{U_S, U_SB, V_ORG, V_S};
			FACE_BOTTOM: ft = (mode == MODE_ROT) ? face_tex_t'{U_S, U_SB, V_S, V_SH}
			                                     : face_tex_t'{U_SB, U_SBB, V_ORG, V_S};
			FACE_FRONT:  ft = (mode == MODE_ROT) ? face_tex_t'{U_S, U_SB, V_ORG, V_S}
			                                     : face_tex_t'{U_S, U_SB, V_S, V_SH};
			FACE_BACK:   ft = (mode == MODE_ROT) ? face_tex_t'{U_SB, U_SBB, V_ORG, V_S}
			                                     : face_tex_t'{U_SSB, U_SSBB, V_S, V_SH};
			FACE_LEFT:   ft = face_tex_t'{U_ORG, U_S, V_S, V_SH};
			FACE_RIGHT:  ft = face_tex_t'{U_SB, U_SSB, V_S, V_SH};
			default:     ft = '0;
		endcase
		return ft;
	endfunction

endpackage

`default_nettype wire

// ===== design/btq_if.sv =====
// ----------------------------------------------------------------------------
// btq_box_if / btq_vtx_if
// Valid/ready channels for box requests and vertex results.
// ----------------------------------------------------------------------------
`default_nettype none

interface btq_box_if import btq_pkg::*;;
	logic valid;
	logic ready;
	box_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface btq_vtx_if import btq_pkg::*;;
	logic valid;
	logic ready;
	vtx_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/box_to_textured_quads_core.sv =====
// ----------------------------------------------------------------------------
// box_to_textured_quads_core
// Expands each box request into the 24 textured vertices of its six faces.
// ----------------------------------------------------------------------------
// Channel   Modport   Payload  Per request
// box       sink      box_t    one box
// vertex    source    vtx_t    one vertex, 24 per box
//
// The corner sequencer fills the single output register, one vertex per cycle
// unless the vertex channel stalls. The first vertex of a box passes through
// the queue and then the output register. A two-entry queue holds classified
// boxes, the one being walked included. A vertex stall freezes the sequencer;
// box ready drops only when the queue is full. Reset clears the queue, the
// sequencer and the vertex index.
// ----------------------------------------------------------------------------
`default_nettype none

module box_to_textured_quads_core import btq_pkg::*; #(
	parameter int VERTEX_STORE_SIZE = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	btq_box_if.sink    box,
	btq_vtx_if.source  vertex
);

	logic push;
	logic full;
	logic pop;
	logic nonempty;
	job_t job;
	job_t head;

	btq_front u_front (
		.box  (box),
		.full (full),
		.push (push),
		.job  (job)
	);

	btq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (job),
		.full      (full),
		.pop       (pop),
		.nonempty  (nonempty),
		.head      (head)
	);

	btq_back #(
		.VERTEX_STORE_SIZE (VERTEX_STORE_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.nonempty (nonempty),
		.pop      (pop),
		.vertex   (vertex)
	);

endmodule

`default_nettype wire

// ===== design/btq_front.sv =====
// ----------------------------------------------------------------------------
// btq_front
// Accepts box requests and works out the texture net taps for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module btq_front import btq_pkg::*; (
	btq_box_if.sink  box,
	input  logic     full,
	output logic     push,
	output job_t     job
);

	logic [8:0] sbw;
	tex_t       tx;
	tex_t       ty;
	tex_t       u_s;
	tex_t       u_sb;
	tex_t       u_ssb;
	tex_t       v_s;

	assign box.ready = !full;
	assign push      = box.valid && !full;

	assign sbw   = {1'b0, box.payload.sides_w} + {1'b0, box.payload.body_w};
	assign tx    = {1'b0, box.payload.tex_x};
	assign ty    = {1'b0, box.payload.tex_y};
	assign u_s   = tx + TEX_W'(box.payload.sides_w);
	assign u_sb  = tx + TEX_W'(sbw);
	assign u_ssb = u_sb + TEX_W'(box.payload.sides_w);
	assign v_s   = ty + TEX_W'(box.payload.sides_w);

	always_comb begin
		job.mode      = box.payload.mode;
		job.u[U_ORG]  = tx;
		job.u[U_S]    = u_s;
		job.u[U_SB]   = u_sb;
		job.u[U_SSB]  = u_ssb;
		job.u[U_SBB]  = u_sb + TEX_W'(box.payload.body_w);
		job.u[U_SSBB] = u_ssb + TEX_W'(box.payload.body_w);
		job.v[V_ORG]  = ty;
		job.v[V_S]    = v_s;
		job.v[V_SH]   = v_s + TEX_W'(box.payload.body_h);
		job.lo_x      = box.payload.lo_x;
		job.lo_y      = box.payload.lo_y;
		job.lo_z      = box.payload.lo_z;
		job.hi_x      = box.payload.hi_x;
		job.hi_y      = box.payload.hi_y;
		job.hi_z      = box.payload.hi_z;
	end

endmodule

`default_nettype wire

// ===== design/btq_queue.sv =====
// ----------------------------------------------------------------------------
// btq_queue
// Short FIFO of classified boxes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module btq_queue import btq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output job_t head
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ===== design/btq_back.sv =====
// ----------------------------------------------------------------------------
// btq_back
// Vertex sequencer: walks the 24 corners of the queue head into the output
// register, one per unstalled cycle, and keeps the running vertex index.
// ----------------------------------------------------------------------------
`default_nettype none

module btq_back import btq_pkg::*; #(
	parameter int VERTEX_STORE_SIZE = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       nonempty,
	output logic       pop,
	btq_vtx_if.source  vertex
);

	localparam logic [16:0]      LAST_IDX = 17'(VERTEX_STORE_SIZE - 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FACE_VERTS - 1);

	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      idx_q;
	logic             out_valid_q;
	vtx_t             out_q;

	logic       advance;
	logic       emit;
	logic [2:0] sel;
	face_tex_t  ft;
	logic       v_low;
	vtx_t       nxt;

	assign advance = !out_valid_q || vertex.ready;
	assign emit    = advance && nonempty;
	assign pop     = emit && (cnt_q == LAST_CNT);

	assign sel   = (head.mode == MODE_ROT) ? SEL_ROT[cnt_q] : SEL_PLAIN[cnt_q];
	assign ft    = face_tex(head.mode, face_t'(cnt_q[CNT_W-1:2]));
	// corners 1 and 2 sit on the upper texture row
	assign v_low = cnt_q[1] ^ cnt_q[0];

	always_comb begin
		nxt.vertex_index = idx_q;
		nxt.pos_x        = sel[SEL_X] ? head.hi_x : head.lo_x;
		nxt.pos_y        = sel[SEL_Y] ? head.hi_y : head.lo_y;
		nxt.pos_z        = sel[SEL_Z] ? head.hi_z : head.lo_z;
		nxt.tex_u        = cnt_q[1] ? head.u[ft.u_hi] : head.u[ft.u_lo];
		nxt.tex_v        = v_low ? head.v[ft.v_lo] : head.v[ft.v_hi];
		nxt.last         = (cnt_q == LAST_CNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= nonempty;
			if (emit) begin
				cnt_q <= (cnt_q == LAST_CNT) ? '0 : cnt_q + 1'b1;
				idx_q <= ({1'b0, idx_q} == LAST_IDX) ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= nxt;
	end

	assign vertex.valid   = out_valid_q;
	assign vertex.payload = out_q;

endmodule

`default_nettype wire

// ===== design/btq_checker.sv =====
// ----------------------------------------------------------------------------
// btq_checker
// Port-level checks of the box-to-quad expander, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_to_textured_quads_core_assert.svh"

module btq_checker import btq_pkg::*; #(
	parameter int VERTEX_STORE_SIZE = 65536
) (
	input logic clk,
	input logic arst_n,
	input logic box_valid,
	input logic box_ready,
	input logic vertex_valid,
	input logic vertex_ready,
	input vtx_t vertex_payload
);

	localparam logic [16:0] LAST_IDX = 17'(VERTEX_STORE_SIZE - 1);

	logic             box_acc;
	logic             vtx_acc;
	logic             seen_q;
	logic [15:0]      prev_idx_q;
	logic [15:0]      exp_idx;
	logic [CNT_W-1:0] vcnt_q;
	logic [7:0]       pend_q;

	assign box_acc = box_valid && box_ready;
	assign vtx_acc = vertex_valid && vertex_ready;
	assign exp_idx = ({1'b0, prev_idx_q} == LAST_IDX) ? '0 : prev_idx_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			prev_idx_q <= '0;
			vcnt_q     <= '0;
			pend_q     <= '0;
		end else begin
			if (vtx_acc) begin
				seen_q     <= 1'b1;
				prev_idx_q <= vertex_payload.vertex_index;
				vcnt_q     <= (vcnt_q == CNT_W'(FACE_VERTS - 1)) ? '0 : vcnt_q + 1'b1;
			end
			pend_q <= pend_q + (box_acc ? 8'(FACE_VERTS) : 8'd0) - (vtx_acc ? 8'd1 : 8'd0);
		end
	end

	`BTQ_ASSERT_HOLD(a_vertex_hold, vertex_valid, vertex_ready, vertex_payload, "vertex request changed while stalled")
	`BTQ_ASSERT(a_index_step, (vtx_acc && seen_q) |-> (vertex_payload.vertex_index == exp_idx), "vertex index did not step by one")
	`BTQ_ASSERT(a_last_flag, vtx_acc |-> (vertex_payload.last == (vcnt_q == CNT_W'(FACE_VERTS - 1))), "last flag off the 24-vertex boundary")
	`BTQ_ASSERT(a_no_extra, vertex_valid |-> (pend_q != 8'd0), "vertex shown with no box outstanding")

endmodule

bind box_to_textured_quads_core btq_checker #(
	.VERTEX_STORE_SIZE (VERTEX_STORE_SIZE)
) u_btq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.box_valid      (box.valid),
	.box_ready      (box.ready),
	.vertex_valid   (vertex.valid),
	.vertex_ready   (vertex.ready),
	.vertex_payload (vertex.payload)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Box-to-quad expander bench: a short table of boxes (extremes, both
// layouts, reversed and degenerate corners), then random boxes. Every
// vertex is checked field by field against a local expansion of each
// accepted box request.
// ----------------------------------------------------------------------------

module tb_top;
	import btq_pkg::*;

	localparam int INDEX_SPAN    = 65536;
	localparam int SWAPPED_VERTS = 8;
	localparam int RANDOM_BOXES  = 106;
	localparam int DRAIN_CYCLES  = FACE_VERTS + 8;
	localparam int DIRECTED_ROWS = 14;

	typedef struct packed {
		logic has_first;
		vtx_t first;
		box_t req;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	btq_box_if box_ch ();
	btq_vtx_if vertex_ch ();

	box_to_textured_quads_core #(
		.VERTEX_STORE_SIZE(INDEX_SPAN)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.box   (box_ch),
		.vertex(vertex_ch)
	);

	always #5 clk = ~clk;

	// First vertex typed in where it is obvious; indices follow the row order.
	plan_row_t directed_plan [DIRECTED_ROWS] = '{
		'{1'b1, '{16'd0, 16'h0000, 16'h0000, 16'h0000, 11'd0, 11'd0, 1'b0},
		  '{MODE_PLAIN, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0,
		    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
		'{1'b1, '{16'd24, 16'h7FFF, 16'h7FFF, 16'h8000, 11'd1278, 11'd1278, 1'b0},
		  '{MODE_PLAIN, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255,
		    16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}},
		'{1'b1, '{16'd48, 16'h8000, 16'h7FFF, 16'h7FFF, 11'd1788, 11'd1533, 1'b0},
		  '{MODE_ROT, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255,
		    16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}},
		'{1'b0, '0,
		  '{MODE_ROT, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0,
		    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
		// reversed corners
		'{1'b0, '0,
		  '{MODE_PLAIN, 10'd1023, 10'd1023, 8'd0, 8'd0, 8'd0,
		    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}},
		'{1'b0, '0,
		  '{MODE_ROT, 10'd1023, 10'd1023, 8'd0, 8'd0, 8'd0,
		    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}},
		'{1'b0, '0,
		  '{MODE_PLAIN, 10'd0, 10'd0, 8'd255, 8'd255, 8'd255,
		    16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}},
		'{1'b0, '0,
		  '{MODE_ROT, 10'd0, 10'd0, 8'd255, 8'd0, 8'd255,
		    16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFE}},
		'{1'b0, '0,
		  '{MODE_PLAIN, 10'h2AA, 10'h155, 8'hAA, 8'h55, 8'hAA,
		    16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}},
		'{1'b0, '0,
		  '{MODE_ROT, 10'h155, 10'h2AA, 8'h55, 8'hAA, 8'h55,
		    16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}},
		// degenerate box, both corners equal
		'{1'b0, '0,
		  '{MODE_PLAIN, 10'd512, 10'd3, 8'd1, 8'd2, 8'd3,
		    16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100}},
		'{1'b0, '0,
		  '{MODE_ROT, 10'd7, 10'd1000, 8'd0, 8'd255, 8'd0,
		    16'hFFFF, 16'h0000, 16'hFF00, 16'h00FF, 16'h8001, 16'h7FFE}},
		'{1'b0, '0,
		  '{MODE_PLAIN, 10'd0, 10'd1023, 8'd255, 8'd0, 8'd0,
		    16'h1234, 16'hEDCB, 16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF}},
		'{1'b0, '0,
		  '{MODE_ROT, 10'd1023, 10'd0, 8'd0, 8'd0, 8'd255,
		    16'h0000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h0001, 16'h4000}}
	};

	vtx_t        box_vertices_due [$];
	logic [15:0] next_index;
	int          vert_in_box;
	logic        rot_layout;
	int          fault_count;
	int          burst_left;

	// ---------------- vertex expansion ----------------

	task automatic push_vertex(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic [10:0] u, input logic [10:0] v);
		vtx_t vx;
		vx.vertex_index = next_index;
		vx.pos_x = x;
		// rotated layout swaps Y and Z on the left and right faces
		if (rot_layout == MODE_ROT && vert_in_box >= FACE_VERTS - SWAPPED_VERTS) begin
			vx.pos_y = z;
			vx.pos_z = y;
		end else begin
			vx.pos_y = y;
			vx.pos_z = z;
		end
		vx.tex_u = u;
		vx.tex_v = v;
		vx.last  = (vert_in_box == FACE_VERTS - 1);
		box_vertices_due.push_back(vx);
		next_index = 16'((int'(next_index) + 1) % INDEX_SPAN);
		vert_in_box++;
	endtask

	// face at constant x
	task automatic face_yz(input logic [10:0] tu, input logic [10:0] tv,
			input logic [10:0] tw, input logic [10:0] th,
			input logic [15:0] za, input logic [15:0] zb,
			input logic [15:0] ya, input logic [15:0] yb, input logic [15:0] x);
		push_vertex(x, ya, za, tu, tv + th);
		push_vertex(x, yb, za, tu, tv);
		push_vertex(x, yb, zb, tu + tw, tv);
		push_vertex(x, ya, zb, tu + tw, tv + th);
	endtask

	// face at constant y
	task automatic face_xz(input logic [10:0] tu, input logic [10:0] tv,
			input logic [10:0] tw, input logic [10:0] th,
			input logic [15:0] xa, input logic [15:0] xb,
			input logic [15:0] za, input logic [15:0] zb, input logic [15:0] y);
		push_vertex(xa, y, zb, tu, tv + th);
		push_vertex(xa, y, za, tu, tv);
		push_vertex(xb, y, za, tu + tw, tv);
		push_vertex(xb, y, zb, tu + tw, tv + th);
	endtask

	// face at constant z
	task automatic face_xy(input logic [10:0] tu, input logic [10:0] tv,
			input logic [10:0] tw, input logic [10:0] th,
			input logic [15:0] xa, input logic [15:0] xb,
			input logic [15:0] ya, input logic [15:0] yb, input logic [15:0] z);
		push_vertex(xa, ya, z, tu, tv + th);
		push_vertex(xa, yb, z, tu, tv);
		push_vertex(xb, yb, z, tu + tw, tv);
		push_vertex(xb, ya, z, tu + tw, tv + th);
	endtask

	task automatic expand_box(input box_t b);
		logic [10:0] tx, ty, s, bw, bh, u_s, u_sb, u_ssb, v_s;
		tx    = 11'(b.tex_x);
		ty    = 11'(b.tex_y);
		s     = 11'(b.sides_w);
		bw    = 11'(b.body_w);
		bh    = 11'(b.body_h);
		u_s   = tx + s;
		u_sb  = u_s + bw;
		u_ssb = u_sb + s;
		v_s   = ty + s;
		vert_in_box = 0;
		rot_layout  = b.mode;
		if (b.mode == MODE_PLAIN) begin
			face_xz(u_s, ty, bw, s, b.hi_x, b.lo_x, b.hi_z, b.lo_z, b.hi_y);
			face_xz(u_sb, ty, bw, s, b.hi_x, b.lo_x, b.hi_z, b.lo_z, b.lo_y);
			face_xy(u_s, v_s, bw, bh, b.hi_x, b.lo_x, b.lo_y, b.hi_y, b.lo_z);
			face_xy(u_ssb, v_s, bw, bh, b.lo_x, b.hi_x, b.lo_y, b.hi_y, b.hi_z);
			face_yz(tx, v_s, s, bh, b.hi_z, b.lo_z, b.lo_y, b.hi_y, b.hi_x);
			face_yz(u_sb, v_s, s, bh, b.lo_z, b.hi_z, b.lo_y, b.hi_y, b.lo_x);
		end else begin
			face_xz(u_ssb, v_s, bw, bh, b.lo_x, b.hi_x, b.lo_z, b.hi_z, b.hi_y);
			face_xz(u_s, v_s, bw, bh, b.hi_x, b.lo_x, b.lo_z, b.hi_z, b.lo_y);
			face_xy(u_s, ty, bw, s, b.hi_x, b.lo_x, b.lo_y, b.hi_y, b.lo_z);
			face_xy(u_sb, ty, bw, s, b.lo_x, b.hi_x, b.hi_y, b.lo_y, b.hi_z);
			face_yz(tx, v_s, s, bh, b.hi_y, b.lo_y, b.hi_z, b.lo_z, b.hi_x);
			face_yz(u_sb, v_s, s, bh, b.lo_y, b.hi_y, b.hi_z, b.lo_z, b.lo_x);
		end
	endtask

	// ---------------- stimulus ----------------

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [7:0] rand_size();
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'($urandom_range(1, 8));
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [9:0] rand_tex();
		case ($urandom_range(0, 7))
			0:       return 10'd0;
			1:       return 10'd1023;
			default: return 10'($urandom());
		endcase
	endfunction

	function automatic box_t rand_box();
		box_t b;
		b.mode    = 1'($urandom_range(0, 1));
		b.tex_x   = rand_tex();
		b.tex_y   = rand_tex();
		b.sides_w = rand_size();
		b.body_w  = rand_size();
		b.body_h  = rand_size();
		b.lo_x    = rand_coord();
		b.lo_y    = rand_coord();
		b.lo_z    = rand_coord();
		b.hi_x    = rand_coord();
		b.hi_y    = rand_coord();
		b.hi_z    = rand_coord();
		return b;
	endfunction

	// Bursts of back-to-back requests separated by random gaps.
	task automatic send_box(input box_t b, input logic has_first, input vtx_t first);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				box_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		box_ch.valid   <= 1'b1;
		box_ch.payload <= b;
		@(posedge clk);
		while (!box_ch.ready)
			@(posedge clk);
		expand_box(b);
		if (has_first)
			box_vertices_due[box_vertices_due.size() - FACE_VERTS] = first;
	endtask

	// ---------------- receiver stalls ----------------

	int   stall_style;
	int   style_left;
	int   hold_left;

	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 2);
			style_left  = $urandom_range(50, 300);
		end
		style_left--;
		case (stall_style)
			0: vertex_ch.ready <= 1'b1;
			1: vertex_ch.ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (hold_left == 0) begin
					vertex_ch.ready <= ~vertex_ch.ready;
					hold_left = $urandom_range(1, 6);
				end
				hold_left--;
			end
		endcase
	end

	// ---------------- checking ----------------

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk) begin
		vtx_t want, got;
		if (arst_n && vertex_ch.valid && vertex_ch.ready) begin
			got = vertex_ch.payload;
			if (box_vertices_due.size() == 0) begin
				$error("vertex index %0d arrived with no box request pending",
					got.vertex_index);
				fault_count++;
			end else begin
				want = box_vertices_due.pop_front();
				check_field("vertex_index", want.vertex_index, got.vertex_index);
				check_field("pos_x", want.pos_x, got.pos_x);
				check_field("pos_y", want.pos_y, got.pos_y);
				check_field("pos_z", want.pos_z, got.pos_z);
				check_field("tex_u", want.tex_u, got.tex_u);
				check_field("tex_v", want.tex_v, got.tex_v);
				check_field("last", want.last, got.last);
			end
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		int n;
		arst_n          = 1'b0;
		box_ch.valid    = 1'b0;
		box_ch.payload  = '0;
		vertex_ch.ready = 1'b0;
		next_index      = '0;
		fault_count     = 0;
		burst_left      = 0;
		style_left      = 0;
		hold_left       = 0;
		stall_style     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_ROWS; n++)
			send_box(directed_plan[n].req, directed_plan[n].has_first,
				directed_plan[n].first);

		for (n = 0; n < RANDOM_BOXES; n++)
			send_box(rand_box(), 1'b0, '0);
		box_ch.valid <= 1'b0;

		while (box_vertices_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0 && box_vertices_due.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	initial begin
		#(25_000_000);
		$display("tb_top failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/btq_pkg.sv
design/btq_if.sv
design/btq_front.sv
design/btq_queue.sv
design/btq_back.sv
design/box_to_textured_quads_core.sv
design/btq_checker.sv
dv/tb_top.sv
